>>> rtl/page_frame_free_stack_defines.svh
// Assertion macros for the page frame free stack.
`ifndef PAGE_FRAME_FREE_STACK_DEFINES_SVH
`define PAGE_FRAME_FREE_STACK_DEFINES_SVH

`ifndef SYNTHESIS
`define PFFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pffs assertion failed");
`define PFFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pffs assertion failed");
`else
`define PFFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PFFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/pffs_pkg.sv
// Shared types and constants of the page frame free stack.
`default_nettype none
package pffs_pkg;
	localparam int unsigned PAGE_BITS_DEF   = 12;
	localparam int unsigned STACK_DEPTH_DEF = 65536;
	localparam int unsigned ADDR_BITS_DEF   = 40;
	localparam int unsigned RESERVE_RESET   = 16384;

	localparam logic [1:0] REG_KERNEL_END   = 2'd0;
	localparam logic [1:0] REG_REGION_TOP   = 2'd1;
	localparam logic [1:0] REG_RESERVE_SIZE = 2'd2;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_FREE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_REJECT = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANGE,
		ST_FILL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic done;
		logic trunc;
	} range_flags_t;
endpackage
`default_nettype wire

>>> rtl/pffs_stack_ram.sv
// Single-port-write, registered-read memory holding the stacked frame numbers.
`default_nettype none
module pffs_stack_ram #(
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned WIDTH = 28
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> rtl/pffs_range.sv
// Three-stage pipeline that turns the configured region into a first frame and a page count.
`default_nettype none
module pffs_range #(
	parameter int unsigned PAGE_BITS   = 12,
	parameter int unsigned STACK_DEPTH = 65536,
	parameter int unsigned ADDR_BITS   = 40
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [ADDR_BITS-1:0]                  kernel_end,
	input  wire logic [ADDR_BITS-1:0]                  region_top,
	input  wire logic [ADDR_BITS-1:0]                  reserve_size,
	output pffs_pkg::range_flags_t                     flags,
	output logic      [ADDR_BITS-PAGE_BITS-1:0]        base,
	output logic      [$clog2(STACK_DEPTH+1)-1:0]      count
);
	import pffs_pkg::*;

	localparam int unsigned FRAME_W = ADDR_BITS - PAGE_BITS;
	localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CMP_W   = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;

	logic [FRAME_W:0]   start_sum;
	logic [ADDR_BITS:0] end_diff;
	logic               trunc;

	logic               valid_s1;
	logic               ovf_s1;
	logic [FRAME_W-1:0] start_s1;
	logic [FRAME_W-1:0] end_s1;

	logic               valid_s2;
	logic [FRAME_W-1:0] base_s2;
	logic [FRAME_W-1:0] pages_s2;

	logic               valid_s3;
	logic               trunc_s3;
	logic [FRAME_W-1:0] base_s3;
	logic [CNT_W-1:0]   count_s3;

	// The start is rounded up to a page; a carry out means it left the address space.
	assign start_sum = {1'b0, kernel_end[ADDR_BITS-1:PAGE_BITS]}
		+ (FRAME_W + 1)'(|kernel_end[PAGE_BITS-1:0]);
	assign end_diff  = {1'b0, region_top} - {1'b0, reserve_size};
	assign trunc     = CMP_W'(pages_s2) > CMP_W'(STACK_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s1   <= start_sum[FRAME_W];
		start_s1 <= start_sum[FRAME_W-1:0];
		end_s1   <= end_diff[ADDR_BITS] ? '0 : end_diff[ADDR_BITS-1:PAGE_BITS];

		base_s2  <= start_s1;
		pages_s2 <= (ovf_s1 || (end_s1 < start_s1)) ? '0 : end_s1 - start_s1;

		base_s3  <= base_s2;
		trunc_s3 <= trunc;
		count_s3 <= trunc ? CNT_W'(STACK_DEPTH) : CNT_W'(pages_s2);
	end

	assign flags.done  = valid_s3;
	assign flags.trunc = trunc_s3;
	assign base        = base_s3;
	assign count       = count_s3;
endmodule
`default_nettype wire

>>> rtl/page_frame_free_stack.sv
// Top level of the page frame free stack: control, configuration and output register.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: action; tdata: address
// m_*      out  tuser: status; tdata: page_address, free_count
// cfg_*    in   index 0 kernel_end, 1 region_top, 2 reserve_size
//
// A successful alloc or free makes one stack memory access, then moves to the result state.
// Init runs the range pipeline, then pushes n pages, one write a cycle through the memory port.
// Reset clears the count and control state; the stack memory is not cleared.
// A result waits in the output register while m_tready is low, and the next beat is
// taken only after the pending result has been loaded there.
`default_nettype none
`include "page_frame_free_stack_defines.svh"
module page_frame_free_stack #(
	parameter int unsigned PAGE_BITS   = pffs_pkg::PAGE_BITS_DEF,
	parameter int unsigned STACK_DEPTH = pffs_pkg::STACK_DEPTH_DEF,
	parameter int unsigned ADDR_BITS   = pffs_pkg::ADDR_BITS_DEF
) (
	input  wire logic                                                    clk,
	input  wire logic                                                    arst_n,
	input  wire logic                                                    s_tvalid,
	output logic                                                         s_tready,
	// address
	input  wire logic [((ADDR_BITS+7)/8)*8-1:0]                          s_tdata,
	// action
	input  wire logic [1:0]                                              s_tuser,
	output logic                                                         m_tvalid,
	input  wire logic                                                    m_tready,
	// page_address, free_count
	output logic [((ADDR_BITS+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0]         m_tdata,
	// status
	output logic [1:0]                                                   m_tuser,
	input  wire logic                                                    cfg_we,
	input  wire logic [1:0]                                              cfg_index,
	input  wire logic [ADDR_BITS-1:0]                                    cfg_data
);
	import pffs_pkg::*;

	localparam int unsigned FRAME_W = ADDR_BITS - PAGE_BITS;
	localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW      = $clog2(STACK_DEPTH);
	localparam int unsigned OUT_W   = ((ADDR_BITS + CNT_W + 7) / 8) * 8;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d, count_m1;
	logic [ADDR_BITS-1:0] kernel_end_q, region_top_q, reserve_size_q;

	status_t            res_status_q, res_status_d;
	logic               res_alloc_q, res_alloc_d;
	logic [FRAME_W-1:0] fill_frame_q, fill_frame_d;
	logic [CNT_W-1:0]   fill_left_q, fill_left_d;

	logic               m_tvalid_q;
	logic [ADDR_BITS-1:0] m_page_q;
	status_t            m_status_q;
	logic [CNT_W-1:0]   m_count_q;

	action_t            act;
	logic [ADDR_BITS-1:0] addr;
	logic               accept, out_free, out_load, range_start;
	logic               pop_item;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [FRAME_W-1:0] ram_wdata, ram_rdata;
	range_flags_t       range_flags;
	logic [FRAME_W-1:0] range_base;
	logic [CNT_W-1:0]   range_count;

	assign act      = action_t'(s_tuser);
	assign addr     = s_tdata[ADDR_BITS-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign count_m1 = count_q - 1'b1;
	assign pop_item = accept && (act == ACT_ALLOC) && (count_q != '0);

	pffs_range #(
		.PAGE_BITS   (PAGE_BITS),
		.STACK_DEPTH (STACK_DEPTH),
		.ADDR_BITS   (ADDR_BITS)
	) u_range (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (range_start),
		.kernel_end   (kernel_end_q),
		.region_top   (region_top_q),
		.reserve_size (reserve_size_q),
		.flags        (range_flags),
		.base         (range_base),
		.count        (range_count)
	);

	pffs_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (FRAME_W)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Items run one at a time, so a pushed entry is always written before any later pop reads it.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_alloc_d  = res_alloc_q;
		fill_frame_d = fill_frame_q;
		fill_left_d  = fill_left_q;
		ram_we       = 1'b0;
		ram_waddr    = count_q[AW-1:0];
		ram_wdata    = fill_frame_q;
		ram_re       = 1'b0;
		ram_raddr    = count_m1[AW-1:0];
		range_start  = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_alloc_d  = 1'b0;
					res_status_d = STS_OK;
					state_d      = ST_RESP;
					unique case (act)
						ACT_INIT: begin
							count_d     = '0;
							range_start = 1'b1;
							state_d     = ST_RANGE;
						end
						ACT_ALLOC: begin
							if (count_q == '0) begin
								res_status_d = STS_EMPTY;
							end else begin
								ram_re      = 1'b1;
								count_d     = count_m1;
								res_alloc_d = 1'b1;
							end
						end
						ACT_FREE: begin
							if ((|addr[PAGE_BITS-1:0]) || (addr < kernel_end_q)) begin
								res_status_d = STS_REJECT;
							end else if (count_q == CNT_W'(STACK_DEPTH)) begin
								res_status_d = STS_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = addr[ADDR_BITS-1:PAGE_BITS];
								count_d   = count_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RANGE: begin
				if (range_flags.done) begin
					res_status_d = range_flags.trunc ? STS_FULL : STS_OK;
					fill_frame_d = range_base;
					fill_left_d  = range_count;
					state_d      = (range_count == '0) ? ST_RESP : ST_FILL;
				end
			end
			ST_FILL: begin
				ram_we       = 1'b1;
				count_d      = count_q + 1'b1;
				fill_frame_d = fill_frame_q + 1'b1;
				fill_left_d  = fill_left_q - 1'b1;
				if (fill_left_q == CNT_W'(1)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			m_tvalid_q     <= 1'b0;
			kernel_end_q   <= '0;
			region_top_q   <= '0;
			reserve_size_q <= ADDR_BITS'(RESERVE_RESET);
		end else begin
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KERNEL_END:   kernel_end_q   <= cfg_data;
					REG_REGION_TOP:   region_top_q   <= cfg_data;
					REG_RESERVE_SIZE: reserve_size_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_alloc_q  <= res_alloc_d;
		fill_frame_q <= fill_frame_d;
		fill_left_q  <= fill_left_d;
		if (out_load) begin
			m_page_q   <= res_alloc_q ? {ram_rdata, {PAGE_BITS{1'b0}}} : '0;
			m_status_q <= res_status_q;
			m_count_q  <= count_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({m_count_q, m_page_q});
	assign m_tuser  = m_status_q;

	`PFFS_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(STACK_DEPTH))
	`PFFS_ASSERT_IMPLIES(a_load_free, clk, arst_n, out_load, !m_tvalid_q || m_tready)
	`PFFS_ASSERT_NEXT(a_pop_count, clk, arst_n, pop_item, count_q == $past(count_m1))
endmodule
`default_nettype wire
